@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the sensor command parser RTL.
// Defining SYNTH turns every macro into an empty body for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define SCP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define SCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCP_ASSERT(label, clk, rst_n, prop, msg)
`define SCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/scp_pkg.sv @@
// Types, character constants and prefix match functions of the sensor command parser.
// No dependencies; used by the interfaces, scp_parse and the top level.
`timescale 1ns / 1ps
package scp_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [3:0]  target_t;
	typedef logic [15:0] value_t;

	// Result of one byte step: emit marks a finished, matched frame
	typedef struct packed {
		logic    emit;
		target_t target;
		value_t  value;
	} result_t;

	// Target codes
	localparam target_t TGT_B1   = 4'd0;
	localparam target_t TGT_FM   = 4'd4;
	localparam target_t TGT_DW   = 4'd5;
	localparam target_t TGT_KE1  = 4'd6;
	localparam target_t TGT_KE2  = 4'd7;
	localparam target_t TGT_IN5  = 4'd8;
	localparam target_t TGT_IN6  = 4'd9;
	localparam target_t TGT_IN8  = 4'd10;
	localparam target_t NO_MATCH = 4'd15;

	// ASCII characters
	localparam char_t CHAR_0 = 8'h30;
	localparam char_t CHAR_1 = 8'h31;
	localparam char_t CHAR_2 = 8'h32;
	localparam char_t CHAR_4 = 8'h34;
	localparam char_t CHAR_5 = 8'h35;
	localparam char_t CHAR_6 = 8'h36;
	localparam char_t CHAR_8 = 8'h38;
	localparam char_t CHAR_9 = 8'h39;
	localparam char_t CHAR_B = 8'h42;
	localparam char_t CHAR_D = 8'h44;
	localparam char_t CHAR_E = 8'h45;
	localparam char_t CHAR_F = 8'h46;
	localparam char_t CHAR_I = 8'h49;
	localparam char_t CHAR_K = 8'h4B;
	localparam char_t CHAR_M = 8'h4D;
	localparam char_t CHAR_N = 8'h4E;
	localparam char_t CHAR_W = 8'h57;

	// Two-character prefixes: B1..B4, FM, DW
	function automatic target_t match_two(input char_t a, input char_t b);
		target_t code;
		code = NO_MATCH;
		if (a == CHAR_B && b >= CHAR_1 && b <= CHAR_4)
			code = TGT_B1 + target_t'(b - CHAR_1);
		else if (a == CHAR_F && b == CHAR_M)
			code = TGT_FM;
		else if (a == CHAR_D && b == CHAR_W)
			code = TGT_DW;
		return code;
	endfunction

	// Three-character prefixes: KE1, KE2, IN5, IN6, IN8
	function automatic target_t match_three(input char_t a, input char_t b, input char_t c);
		target_t code;
		code = NO_MATCH;
		if (a == CHAR_K && b == CHAR_E) begin
			if (c == CHAR_1)
				code = TGT_KE1;
			else if (c == CHAR_2)
				code = TGT_KE2;
		end else if (a == CHAR_I && b == CHAR_N) begin
			if (c == CHAR_5)
				code = TGT_IN5;
			else if (c == CHAR_6)
				code = TGT_IN6;
			else if (c == CHAR_8)
				code = TGT_IN8;
		end
		return code;
	endfunction

	function automatic logic is_digit(input char_t b);
		return (b >= CHAR_0) && (b <= CHAR_9);
	endfunction

endpackage

@@ rtl/core/scp_if.sv @@
// Valid/ready channel interfaces of the sensor command parser: command bytes in, results out.
// Depends on scp_pkg.
`timescale 1ns / 1ps
interface scp_byte_if;
	import scp_pkg::*;
	logic  valid;
	logic  ready;
	char_t cmd_byte;
	modport source (output valid, output cmd_byte, input ready);
	modport sink (input valid, input cmd_byte, output ready);
endinterface

interface scp_result_if;
	import scp_pkg::*;
	logic    valid;
	logic    ready;
	target_t target;
	value_t  value;
	modport source (output valid, output target, output value, input ready);
	modport sink (input valid, input target, input value, output ready);
endinterface

@@ rtl/core/sensor_command_parser_core.sv @@
// Sensor command parser: fixed-length ASCII command frames in, (target, value) results out.
//
// Usage:
//   cmd (sink): one raw frame byte per transaction; FRAME_BYTES bytes make a frame.
//   res (source): one transaction per frame whose 2- or 3-character prefix matched,
//     carrying the target code and the decimal value after the prefix (mod 65536).
//   Frames with an unknown prefix produce no transaction.
// Timing:
//   A byte is held in an input register. The frame state update from it and, on the
//   last byte of a matched frame, the load of the output register happen at the same
//   edge, so a result passes the input register and then the output register.
//   Throughput is one byte per cycle unless a second result waits behind a blocked one.
// Stalls:
//   While a result waits in the output register, bytes that produce no result keep
//   flowing; only a second result behind it holds cmd.ready low until res.ready.
// Reset:
//   arst_n clears the frame position, the match state, the accumulator and both
//   valid flags; the first byte after reset starts a new frame.
// Depends on scp_pkg, scp_if, scp_parse and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sensor_command_parser_core #(
	parameter int FRAME_BYTES = 8
) (
	input logic          clk,
	input logic          arst_n,
	scp_byte_if.sink     cmd,
	scp_result_if.source res
);
	import scp_pkg::*;

	logic    valid_s1;
	char_t   byte_s1;
	logic    res_valid_q;
	target_t target_q;
	value_t  value_q;

	result_t step_res;
	logic    out_free;
	logic    s1_go;
	logic    in_acc;

	// Handshake: stage 1 moves on unless it carries a result with nowhere to go
	assign out_free = !res_valid_q || res.ready;
	assign s1_go    = valid_s1 && (!step_res.emit || out_free);
	assign cmd.ready = !valid_s1 || s1_go;
	assign in_acc   = cmd.valid && cmd.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (s1_go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			byte_s1 <= cmd.cmd_byte;
	end

	scp_parse #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_go),
		.cmd_byte(byte_s1),
		.res     (step_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (s1_go && step_res.emit)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && step_res.emit) begin
			target_q <= step_res.target;
			value_q  <= step_res.value;
		end
	end

	assign res.valid  = res_valid_q;
	assign res.target = target_q;
	assign res.value  = value_q;

	// Checks
	`SCP_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_go, valid_s1 && $stable(byte_s1), "stalled byte lost or changed")
	`SCP_ASSERT_IMP(a_blocked_in, clk, arst_n, valid_s1 && step_res.emit && res_valid_q && !res.ready, !cmd.ready, "byte taken while a result is blocked")
	`SCP_ASSERT_IMP(a_target_range, clk, arst_n, res_valid_q, target_q <= TGT_IN8, "result with an unknown target")
	`SCP_ASSERT_NXT(a_load_visible, clk, arst_n, s1_go && step_res.emit, res_valid_q && value_q == $past(step_res.value), "result not loaded")

endmodule

@@ rtl/core/scp_parse.sv @@
// Frame state of the sensor command parser: byte position, prefix match, digit accumulator.
// Depends on scp_pkg.
`timescale 1ns / 1ps
module scp_parse #(
	parameter int FRAME_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  scp_pkg::char_t   cmd_byte,
	output scp_pkg::result_t res
);
	import scp_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	char_t            first_q;
	char_t            second_q;
	target_t          match_q;
	logic             done_q;
	value_t           acc_q;

	target_t match_d;
	logic    done_d;
	value_t  acc_d;
	value_t  acc_step;
	logic    last_byte;

	// value * 10 + digit, wrapping at 16 bits
	assign acc_step = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'd0, cmd_byte[3:0]};
	assign last_byte = (pos_q == LAST_POS);

	// Next frame state for the byte at hand
	always_comb begin
		match_d = match_q;
		done_d  = done_q;
		acc_d   = acc_q;
		if (pos_q == '0) begin
			match_d = NO_MATCH;
			done_d  = 1'b0;
			acc_d   = '0;
		end else if (pos_q == POS_W'(1)) begin
			match_d = match_two(first_q, cmd_byte);
		end else if (pos_q == POS_W'(2) && match_q == NO_MATCH) begin
			match_d = match_three(first_q, second_q, cmd_byte);
		end else if (match_q != NO_MATCH && !done_q) begin
			if (is_digit(cmd_byte))
				acc_d = acc_step;
			else
				done_d = 1'b1;
		end
	end

	assign res.emit   = last_byte && (match_d != NO_MATCH);
	assign res.target = match_d;
	assign res.value  = acc_d;

	// State update, one byte per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			match_q  <= NO_MATCH;
			done_q   <= 1'b0;
			acc_q    <= '0;
		end else if (step) begin
			pos_q   <= last_byte ? '0 : pos_q + POS_W'(1);
			match_q <= match_d;
			done_q  <= done_d;
			acc_q   <= acc_d;
			if (pos_q == '0)
				first_q <= cmd_byte;
			if (pos_q == POS_W'(1))
				second_q <= cmd_byte;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for sensor_command_parser_core: drives 8-byte command frames
// and checks every (target, value) transaction against a frame-level predictor.
// Depends on scp_pkg, scp_if and the parser RTL.
`timescale 1ns / 1ps
module tb;
	import scp_pkg::*;

	localparam int FRAME_BYTES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	// Characters and codes the package does not name
	localparam char_t   CHAR_3 = 8'h33;
	localparam target_t TGT_B2 = 4'd1;
	localparam target_t TGT_B3 = 4'd2;
	localparam target_t TGT_B4 = 4'd3;

	typedef char_t frame_t [FRAME_BYTES];

	typedef struct {
		target_t target;
		value_t  value;
	} parsed_cmd_t;

	logic clk;
	logic arst_n;

	scp_byte_if   cmd_if ();
	scp_result_if res_if ();

	sensor_command_parser_core #(.FRAME_BYTES(FRAME_BYTES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	// Predicted commands still waiting for their result transaction
	parsed_cmd_t pending_cmds [$];

	// Predictor state of the frame parser
	int      frame_pos;
	char_t   head0;
	char_t   head1;
	target_t cur_target;
	bit      number_closed;
	value_t  running_value;

	bit source_gaps;
	bit sink_stalls;
	int stall_left;
	int failures;
	int bytes_sent;
	int frames_sent;
	int cmds_checked;
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Prefix decoding, two-character names
	function automatic target_t short_prefix_code(input char_t c0, input char_t c1);
		target_t code;
		code = NO_MATCH;
		case (c0)
			CHAR_B: begin
				case (c1)
					CHAR_1: code = TGT_B1;
					CHAR_2: code = TGT_B2;
					CHAR_3: code = TGT_B3;
					CHAR_4: code = TGT_B4;
					default: code = NO_MATCH;
				endcase
			end
			CHAR_F: if (c1 == CHAR_M) code = TGT_FM;
			CHAR_D: if (c1 == CHAR_W) code = TGT_DW;
			default: code = NO_MATCH;
		endcase
		return code;
	endfunction

	// Prefix decoding, three-character names
	function automatic target_t long_prefix_code(input char_t c0, input char_t c1,
			input char_t c2);
		target_t code;
		code = NO_MATCH;
		if (c0 == CHAR_K && c1 == CHAR_E) begin
			case (c2)
				CHAR_1: code = TGT_KE1;
				CHAR_2: code = TGT_KE2;
				default: code = NO_MATCH;
			endcase
		end else if (c0 == CHAR_I && c1 == CHAR_N) begin
			case (c2)
				CHAR_5: code = TGT_IN5;
				CHAR_6: code = TGT_IN6;
				CHAR_8: code = TGT_IN8;
				default: code = NO_MATCH;
			endcase
		end
		return code;
	endfunction

	function automatic bit is_decimal(input char_t b);
		return b >= CHAR_0 && b <= CHAR_9;
	endfunction

	function automatic char_t random_non_digit();
		char_t b;
		do
			b = char_t'($urandom_range(0, 255));
		while (is_decimal(b));
		return b;
	endfunction

	function automatic char_t random_digit();
		return char_t'(CHAR_0 + $urandom_range(0, 9));
	endfunction

	// Predictor: advance the frame state by one accepted byte
	task automatic parse_byte(input char_t b);
		if (frame_pos == 0) begin
			head0 = b;
			cur_target = NO_MATCH;
			number_closed = 1'b0;
			running_value = '0;
		end else if (frame_pos == 1) begin
			head1 = b;
			cur_target = short_prefix_code(head0, b);
		end else if (frame_pos == 2 && cur_target == NO_MATCH) begin
			cur_target = long_prefix_code(head0, head1, b);
		end else if (cur_target != NO_MATCH && !number_closed) begin
			if (is_decimal(b))
				running_value = value_t'(running_value * 10 + (b - CHAR_0));
			else
				number_closed = 1'b1;
		end
		// last byte of the frame: a matched prefix yields one command
		if (frame_pos == FRAME_BYTES - 1) begin
			if (cur_target != NO_MATCH)
				pending_cmds.push_back('{target: cur_target, value: running_value});
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
	endtask

	// Send one byte; called and returns at a falling edge, valid left high
	task automatic send_byte(input char_t b);
		if (source_gaps && $urandom_range(0, 5) == 0) begin
			cmd_if.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_if.valid = 1'b1;
		cmd_if.cmd_byte = b;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_t f);
		for (int i = 0; i < FRAME_BYTES; i++)
			send_byte(f[i]);
		frames_sent++;
	endtask

	// Stop sending and wait until every predicted command has come out
	task automatic drain_cmds();
		cmd_if.valid = 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic frame_t frame_from_text(input string s);
		frame_t f;
		for (int i = 0; i < FRAME_BYTES; i++)
			f[i] = (i < s.len()) ? char_t'(s[i]) : 8'h00;
		return f;
	endfunction

	// Matched prefix, a run of digits, then, if room is left, a terminator and trailing junk
	function automatic frame_t well_formed_frame(input target_t code);
		frame_t f;
		int plen;
		int ndig;
		int i;
		plen = 3;
		case (code)
			TGT_B1, TGT_B2, TGT_B3, TGT_B4: begin
				f[0] = CHAR_B;
				f[1] = char_t'(CHAR_1 + (code - TGT_B1));
				plen = 2;
			end
			TGT_FM: begin
				f[0] = CHAR_F;
				f[1] = CHAR_M;
				plen = 2;
			end
			TGT_DW: begin
				f[0] = CHAR_D;
				f[1] = CHAR_W;
				plen = 2;
			end
			TGT_KE1, TGT_KE2: begin
				f[0] = CHAR_K;
				f[1] = CHAR_E;
				f[2] = (code == TGT_KE1) ? CHAR_1 : CHAR_2;
			end
			default: begin
				f[0] = CHAR_I;
				f[1] = CHAR_N;
				f[2] = (code == TGT_IN5) ? CHAR_5 : (code == TGT_IN6) ? CHAR_6 : CHAR_8;
			end
		endcase
		// bias toward long digit runs so the value often wraps
		ndig = ($urandom_range(0, 2) == 0) ? $urandom_range(0, FRAME_BYTES - plen)
			: FRAME_BYTES - plen - $urandom_range(0, 1);
		i = plen;
		repeat (ndig) begin
			f[i] = random_digit();
			i++;
		end
		if (i < FRAME_BYTES) begin
			f[i] = random_non_digit();
			i++;
		end
		while (i < FRAME_BYTES) begin
			f[i] = $urandom_range(0, 1) ? random_digit() : char_t'($urandom_range(0, 255));
			i++;
		end
		return f;
	endfunction

	// Prefix built from plausible characters: mostly misses, some hits
	function automatic frame_t near_miss_frame();
		frame_t f;
		string starters;
		string near_chars;
		starters = "BFDKI";
		near_chars = "BFDKIEMWN0123456789";
		f[0] = char_t'(starters[$urandom_range(0, starters.len() - 1)]);
		for (int i = 1; i < 3; i++)
			f[i] = $urandom_range(0, 3) != 0
				? char_t'(near_chars[$urandom_range(0, near_chars.len() - 1)])
				: char_t'($urandom_range(0, 255));
		for (int i = 3; i < FRAME_BYTES; i++)
			f[i] = $urandom_range(0, 3) != 0 ? random_digit() : random_non_digit();
		return f;
	endfunction

	function automatic frame_t noise_frame();
		frame_t f;
		for (int i = 0; i < FRAME_BYTES; i++)
			f[i] = char_t'($urandom_range(0, 255));
		return f;
	endfunction

	function automatic frame_t random_frame();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return well_formed_frame(target_t'($urandom_range(TGT_B1, TGT_IN8)));
		else if (pick < 85)
			return near_miss_frame();
		return noise_frame();
	endfunction

	// Zero frame, wrap-around, full-scale value, missing and ignored digits
	task automatic test_directed_frames();
		frame_t f;
		send_frame(frame_from_text(""));
		send_frame(frame_from_text("IN899999"));
		send_frame(frame_from_text("B165535"));
		f = frame_from_text("FM?12345");
		f[2] = 8'hFF;
		send_frame(f);
	endtask

	task automatic test_each_target();
		for (int code = TGT_B1; code <= TGT_IN8; code++)
			send_frame(well_formed_frame(target_t'(code)));
	endtask

	// Mixed frames, with idling on both sides switched in stretches
	task automatic test_random_frames(input int n_frames);
		repeat (n_frames) begin
			if ($urandom_range(0, 7) == 0) begin
				source_gaps = $urandom_range(0, 3) != 0;
				sink_stalls = $urandom_range(0, 3) != 0;
			end
			send_frame(random_frame());
		end
	endtask

	// Sender holds off until the output side has caught up completely
	task automatic test_pause_until_drained();
		repeat (2) begin
			send_frame(random_frame());
			send_frame(well_formed_frame(target_t'($urandom_range(TGT_B1, TGT_IN8))));
			drain_cmds();
		end
	endtask

	task automatic test_back_to_back(input int n_frames);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (n_frames)
			send_frame(random_frame());
	endtask

	// Result sink: ready drops in random bursts while stalls are enabled
	initial begin
		res_if.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && sink_stalls && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 6);
			res_if.ready = (stall_left == 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		parsed_cmd_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual target %0d value %0d",
					$time, res_if.target, res_if.value);
				failures++;
			end else begin
				want = pending_cmds.pop_front();
				cmds_checked++;
				if (res_if.target !== want.target) begin
					$display("%0t: target mismatch, expected %0d actual %0d",
						$time, want.target, res_if.target);
					failures++;
				end
				if (res_if.value !== want.value) begin
					$display("%0t: value mismatch, expected %0d actual %0d",
						$time, want.value, res_if.value);
					failures++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding",
				cycle_count, pending_cmds.size());
			$display("sensor_command_parser_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.cmd_byte = '0;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		failures = 0;
		bytes_sent = 0;
		frames_sent = 0;
		cmds_checked = 0;
		cycle_count = 0;
		frame_pos = 0;
		head0 = '0;
		head1 = '0;
		cur_target = NO_MATCH;
		number_closed = 1'b0;
		running_value = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frames();
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		test_each_target();
		test_random_frames(55);
		test_pause_until_drained();
		test_back_to_back(10);

		drain_cmds();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d bytes in %0d frames (all targets, wrap, bad prefixes, noise)",
			bytes_sent, frames_sent);
		$display("checked %0d result transactions under random gaps and stalls",
			cmds_checked);
		if (failures == 0)
			$display("sensor_command_parser_core test passed");
		else
			$display("sensor_command_parser_core test failed");
		$finish;
	end

endmodule
